// ===== design/flight_arming_mode_controller_defines.svh =====
// Assertion macros for the flight arming mode controller.
// Used by files that check their own logic; expects clk and arst_n in scope.
`ifndef FLIGHT_ARMING_MODE_CONTROLLER_DEFINES_SVH
`define FLIGHT_ARMING_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FAM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fam: property violated");

// Next-cycle implication, checked out of reset.
`define FAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fam: property violated");

`endif

// ===== design/fam_pkg.sv =====
// Shared types, codes and constants of the flight arming mode controller.
// No dependencies; every other file but the defines header imports it.
package fam_pkg;

	localparam int unsigned SW_W     = 2;
	localparam int unsigned THR_W    = 8;
	localparam int unsigned DT_W     = 16;
	localparam int unsigned IDLE_W   = 18;
	localparam int unsigned BUZZ_W   = 17;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned ACT_W    = 2;
	localparam int unsigned CUT_W    = 8;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [BUZZ_W-1:0] BUZZER_LATCH_MS = BUZZ_W'(120000);
	localparam logic [IDLE_W-1:0] MS_PER_SEC      = IDLE_W'(1000);
	localparam logic [THR_W-1:0]  IDLE_LEVEL_RST  = '0;
	localparam logic [CUT_W-1:0]  IDLE_CUT_RST    = CUT_W'(20);

	// Register indexes (paddr bit 2)
	localparam logic REG_IDLE_LEVEL = 1'b0;
	localparam logic REG_IDLE_CUT   = 1'b1;

	// Mode switch readings
	localparam logic [SW_W-1:0] SW_DISARMED = 2'd0;
	localparam logic [SW_W-1:0] SW_ANGLE    = 2'd1;
	localparam logic [SW_W-1:0] SW_ACCRO    = 2'd2;

	// Reported state codes
	localparam logic [CODE_W-1:0] CODE_INIT     = 3'd0;
	localparam logic [CODE_W-1:0] CODE_START    = 3'd1;
	localparam logic [CODE_W-1:0] CODE_ANGLE    = 3'd2;
	localparam logic [CODE_W-1:0] CODE_ACCRO    = 3'd3;
	localparam logic [CODE_W-1:0] CODE_SAFETY   = 3'd4;
	localparam logic [CODE_W-1:0] CODE_DISARMED = 3'd5;

	// Drive actions
	localparam logic [ACT_W-1:0] ACT_IDLE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ANGLE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_ACCRO = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RESET = 2'd3;

	typedef enum logic [5:0] {
		ST_INIT     = 6'b000001,
		ST_START    = 6'b000010,
		ST_ANGLE    = 6'b000100,
		ST_ACCRO    = 6'b001000,
		ST_SAFETY   = 6'b010000,
		ST_DISARMED = 6'b100000
	} state_t;

	typedef struct packed {
		logic [SW_W-1:0]  switch_first;
		logic [SW_W-1:0]  switch_second;
		logic [THR_W-1:0] throttle_level;
		logic [DT_W-1:0]  elapsed_ms;
	} sample_t;

	typedef struct packed {
		logic [CODE_W-1:0] flight_state;
		logic [ACT_W-1:0]  drive_action;
		logic              buzzer_on;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0] idle_throttle_level;
		logic [CUT_W-1:0] idle_cut_seconds;
	} cfg_t;

	function automatic logic [CODE_W-1:0] state_code(state_t s);
		logic [CODE_W-1:0] c;
		unique case (s)
			ST_START:    c = CODE_START;
			ST_ANGLE:    c = CODE_ANGLE;
			ST_ACCRO:    c = CODE_ACCRO;
			ST_SAFETY:   c = CODE_SAFETY;
			ST_DISARMED: c = CODE_DISARMED;
			default:     c = CODE_INIT;
		endcase
		return c;
	endfunction

endpackage

// ===== design/fam_ifs.sv =====
// Valid/ready channel interfaces for samples and results.
// Depends on fam_pkg for the field widths.
interface fam_sample_if import fam_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SW_W-1:0]  switch_first;
	logic [SW_W-1:0]  switch_second;
	logic [THR_W-1:0] throttle_level;
	logic [DT_W-1:0]  elapsed_ms;

	modport source (output valid, switch_first, switch_second, throttle_level, elapsed_ms,
		input ready);
	modport sink (input valid, switch_first, switch_second, throttle_level, elapsed_ms,
		output ready);
endinterface

interface fam_result_if import fam_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] flight_state;
	logic [ACT_W-1:0]  drive_action;
	logic              buzzer_on;

	modport source (output valid, flight_state, drive_action, buzzer_on, input ready);
	modport sink (input valid, flight_state, drive_action, buzzer_on, output ready);
endinterface

// ===== design/fam_cfg_regs.sv =====
// APB register file: idle throttle level and idle cut time.
// Depends on fam_pkg.
module fam_cfg_regs import fam_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Byte-lane bits are ignored on writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_throttle_level <= IDLE_LEVEL_RST;
			cfg_q.idle_cut_seconds    <= IDLE_CUT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_IDLE_LEVEL: cfg_q.idle_throttle_level <= pwdata[THR_W-1:0];
				REG_IDLE_CUT:   cfg_q.idle_cut_seconds    <= pwdata[CUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_IDLE_LEVEL: prdata = APB_DW'(cfg_q.idle_throttle_level);
				REG_IDLE_CUT:   prdata = APB_DW'(cfg_q.idle_cut_seconds);
				default:        prdata = '0;
			endcase
		end
	end

endmodule

// ===== design/fam_core.sv =====
// Mode state machine, idle and buzzer timers, per-sample next-state rule.
// Depends on fam_pkg.
module fam_core import fam_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  sample_t sample,
	input  cfg_t    cfg,
	output result_t result
);

	state_t              state_q, state_d;
	logic                twh_q, twh_d;
	logic                latch_q, latch_d;
	logic [IDLE_W-1:0]   idle_q, idle_d, idle_add, cut_ms;
	logic [BUZZ_W-1:0]   buzz_q, buzz_d, buzz_add;
	logic [IDLE_W:0]     idle_sum;
	logic [BUZZ_W:0]     buzz_sum;
	logic [ACT_W-1:0]    act;
	logic                buzz;
	logic                sw_agree;
	logic                thr_high;

	// Saturating timer advance
	assign idle_sum = {1'b0, idle_q} + (IDLE_W+1)'(sample.elapsed_ms);
	assign buzz_sum = {1'b0, buzz_q} + (BUZZ_W+1)'(sample.elapsed_ms);
	assign idle_add = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];
	assign buzz_add = buzz_sum[BUZZ_W] ? '1 : buzz_sum[BUZZ_W-1:0];
	assign cut_ms   = IDLE_W'(cfg.idle_cut_seconds) * MS_PER_SEC;
	assign sw_agree = sample.switch_first == sample.switch_second;
	assign thr_high = sample.throttle_level > cfg.idle_throttle_level;

	always_comb begin
		state_d = state_q;
		twh_d   = twh_q;
		latch_d = latch_q;
		idle_d  = idle_add;
		buzz_d  = buzz_add;
		act     = ACT_IDLE;
		buzz    = 1'b0;
		unique case (state_q)
			ST_START: begin
				if (latch_q) buzz = 1'b1;
				else if (buzz_add > BUZZER_LATCH_MS) latch_d = 1'b1;
				if (sw_agree && sample.switch_first == SW_ANGLE) state_d = ST_ANGLE;
				else if (sw_agree && sample.switch_first == SW_ACCRO) state_d = ST_ACCRO;
			end
			ST_ANGLE, ST_ACCRO: begin
				if (thr_high) begin
					twh_d = 1'b1;
					if (state_q == ST_ANGLE) begin
						act = ACT_ANGLE;
						if (sample.switch_first == SW_ACCRO) state_d = ST_ACCRO;
					end else begin
						act = ACT_ACCRO;
						if (sample.switch_first == SW_ANGLE) state_d = ST_ANGLE;
					end
				end else begin
					act = ACT_RESET;
					// Throttle dropped after flight: restart timers and unlatch
					if (twh_q) begin
						idle_d  = '0;
						buzz_d  = '0;
						latch_d = 1'b0;
						twh_d   = 1'b0;
					end else if (idle_add > cut_ms) begin
						state_d = ST_SAFETY;
					end
				end
			end
			ST_SAFETY: begin
				if (latch_q) buzz = 1'b1;
				else if (buzz_add > BUZZER_LATCH_MS) latch_d = 1'b1;
				if (sample.switch_first == SW_DISARMED) state_d = ST_DISARMED;
			end
			ST_DISARMED: begin
				if (latch_q) buzz = 1'b1;
				else if (buzz_add > BUZZER_LATCH_MS) latch_d = 1'b1;
				if (sw_agree && sample.switch_first != SW_DISARMED) begin
					twh_d = 1'b1;
					if (sample.switch_first == SW_ANGLE) state_d = ST_ANGLE;
					else if (sample.switch_first == SW_ACCRO) state_d = ST_ACCRO;
				end
			end
			default: begin
				state_d = (sample.switch_first == SW_DISARMED) ? ST_START : ST_INIT;
			end
		endcase
	end

	assign result.flight_state = state_code(state_d);
	assign result.drive_action = act;
	assign result.buzzer_on    = buzz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			twh_q   <= 1'b0;
			latch_q <= 1'b0;
			idle_q  <= '0;
			buzz_q  <= '0;
		end else if (advance) begin
			state_q <= state_d;
			twh_q   <= twh_d;
			latch_q <= latch_d;
			idle_q  <= idle_d;
			buzz_q  <= buzz_d;
		end
	end

endmodule

// ===== design/flight_arming_mode_controller.sv =====
// Flight arming mode controller: input register, next-state core, result register.
// Depends on fam_pkg, fam_ifs, fam_cfg_regs, fam_core and the defines header.
//
// Usage:
//   sample_in carries one control-loop sample per transaction (two switch
//   readings, throttle, elapsed ms). result_out carries one result per sample:
//   flight state after the step, drive action and buzzer request.
//   Registers are written over the APB port (idle throttle level at 0x0, idle
//   cut seconds at 0x4); write them only while no sample is in flight.
//   A sample accepted into the input register is stepped by the next-state
//   core into the result register. Throughput: one sample per cycle while
//   result_out is not stalled, set by the combinational next-state core.
//   A stalled result_out holds its transaction; sample_in still takes one more
//   sample into the input register, then deasserts ready until the result drains.
//   Reset: state init, both timers and the buzzer latch clear, idle throttle
//   level 0, idle cut 20 s; no result is pending.
`include "flight_arming_mode_controller_defines.svh"

module flight_arming_mode_controller import fam_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fam_sample_if.sink        sample_in,
	fam_result_if.source      result_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	sample_t sample_s1;
	logic    valid_s1;
	result_t res_d, res_q;
	logic    out_valid_q;
	logic    advance;

	fam_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fam_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sample  (sample_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	// Advance when the result register is free or draining this cycle
	assign advance         = valid_s1 && (!out_valid_q || result_out.ready);
	assign sample_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_in.ready) valid_s1 <= sample_in.valid;
			if (advance) out_valid_q <= 1'b1;
			else if (result_out.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.ready && sample_in.valid) begin
			sample_s1.switch_first   <= sample_in.switch_first;
			sample_s1.switch_second  <= sample_in.switch_second;
			sample_s1.throttle_level <= sample_in.throttle_level;
			sample_s1.elapsed_ms     <= sample_in.elapsed_ms;
		end
		if (advance) res_q <= res_d;
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.flight_state = res_q.flight_state;
	assign result_out.drive_action = res_q.drive_action;
	assign result_out.buzzer_on    = res_q.buzzer_on;

	`FAM_ASSERT_IMPL(a_stall_cause, !sample_in.ready,
		valid_s1 && out_valid_q && !result_out.ready)
	`FAM_ASSERT_NEXT(a_result_loaded, advance, out_valid_q)
	`FAM_ASSERT_IMPL(a_buzz_state, out_valid_q && res_q.buzzer_on,
		res_q.drive_action == ACT_IDLE && res_q.flight_state != CODE_INIT)
	`FAM_ASSERT_IMPL(a_stab_state, out_valid_q && (res_q.drive_action == ACT_ANGLE ||
		res_q.drive_action == ACT_ACCRO),
		res_q.flight_state == CODE_ANGLE || res_q.flight_state == CODE_ACCRO)

endmodule
